// ----- sv/rdrs_pkg.sv -----
package rdrs_pkg;

  // default largest image dimension
  localparam int unsigned MAX_DIM_DEF = 4096;

  // field widths
  localparam int unsigned IDX_W   = 12;
  localparam int unsigned DIM_W   = 13;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned RAD_W   = 20;
  localparam int unsigned RAT_W   = 16;
  localparam int unsigned DENS_W  = 32;

  // internal datapath widths
  localparam int unsigned OFS_W   = 29;  // |2i+1-n| * len
  localparam int unsigned SQ_W    = 58;  // one squared axis term
  localparam int unsigned SUM_W   = 59;  // squared distance
  localparam int unsigned RADC_W  = 60;  // radicand fed to the root chain
  localparam int unsigned ROOT_W  = 30;
  localparam int unsigned SREM_W  = 32;
  localparam int unsigned SQRT_N  = 30;  // one root bit per cell
  localparam int unsigned SPAN_W  = 29;
  localparam int unsigned NUM_W   = 46;
  localparam int unsigned DNUM_W  = 58;
  localparam int unsigned QUO_W   = 28;
  localparam int unsigned DIV_N   = 28;  // one quotient bit per cell
  localparam int unsigned FAC_W   = 29;
  localparam int unsigned PROD_W  = 62;

  // register indexes
  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_LENX   = 3'd2;
  localparam logic [2:0] REG_LENY   = 3'd3;
  localparam logic [2:0] REG_INNER  = 3'd4;
  localparam logic [2:0] REG_OUTER  = 3'd5;
  localparam logic [2:0] REG_RATIO  = 3'd6;
  localparam logic [2:0] REG_MODE   = 3'd7;

  // radial zone of a voxel
  typedef logic [1:0] zone_t;
  localparam zone_t ZONE_IN   = 2'd0;
  localparam zone_t ZONE_RAMP = 2'd1;
  localparam zone_t ZONE_OUT  = 2'd2;

endpackage

// ----- sv/radial_density_ramp_scaler.sv -----
// Radial density ramp scaler.
// Input stream in_*: one voxel per transaction, in_tdata holds col_index,
// row_index and density_in. Output stream out_*: one scaled density per
// input transaction, in the same order. Configuration port cfg_*: one
// register write per transaction, always ready; write only while no voxel
// is in flight.
// Path: stages 0-3, root cells, numerator, divider cells, product, output.
// Throughput: one voxel per cycle; the chain of 30 square root cells and
// 28 divider cells each retire one bit per cycle, so the rate is set only
// by the handshake.
// When the receiver holds out_tready low with a result waiting, the whole
// chain freezes and in_tready drops; voxels in flight keep their place and
// flow on once out_tready returns. Bubbles in the chain move along with
// the voxels and are not squeezed out.
// Reset (rst_n low, synchronous) empties the chain and loads the register
// defaults: 1x1 image, unit pixel length, inner radius 0, outer radius 1,
// ratio 1, mode 0.
module radial_density_ramp_scaler #(
  parameter int unsigned MAX_DIM = rdrs_pkg::MAX_DIM_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // col_index[11:0], row_index[23:12], density_in[55:24]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // density_out[31:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int unsigned SQ0 = 4;                          // first root cell stage
  localparam int unsigned NST = SQ0 + rdrs_pkg::SQRT_N;     // numerator stage
  localparam int unsigned DV0 = NST + 1;                    // first divider cell stage
  localparam int unsigned QST = DV0 + rdrs_pkg::DIV_N - 1;  // quotient stage
  localparam int unsigned PST = QST + 1;                    // product stage
  localparam logic [31:0] MaxDimW = 32'(MAX_DIM);

  // configuration registers
  logic [rdrs_pkg::DIM_W-1:0] width_r, height_r;
  logic [rdrs_pkg::LEN_W-1:0] lenx_r, leny_r;
  logic [rdrs_pkg::RAD_W-1:0] inner_r, outer_r;
  logic [rdrs_pkg::RAT_W-1:0] ratio_r;
  logic                       mode_r;
  logic [rdrs_pkg::DIM_W-1:0] dim_nxt;

  assign cfg_ready = 1'b1;

  // clamp a dimension write to 1..MAX_DIM
  always_comb begin
    dim_nxt = cfg_data[rdrs_pkg::DIM_W-1:0];
    if (dim_nxt == '0) begin
      dim_nxt = 13'd1;
    end else if ({19'd0, dim_nxt} > MaxDimW) begin
      dim_nxt = MaxDimW[rdrs_pkg::DIM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 13'd1;
      height_r <= 13'd1;
      lenx_r   <= 16'd4096;
      leny_r   <= 16'd4096;
      inner_r  <= '0;
      outer_r  <= 20'd16;
      ratio_r  <= 16'd4096;
      mode_r   <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        rdrs_pkg::REG_WIDTH:  width_r  <= dim_nxt;
        rdrs_pkg::REG_HEIGHT: height_r <= dim_nxt;
        rdrs_pkg::REG_LENX:   lenx_r   <= cfg_data[15:0];
        rdrs_pkg::REG_LENY:   leny_r   <= cfg_data[15:0];
        rdrs_pkg::REG_INNER:  inner_r  <= cfg_data[19:0];
        rdrs_pkg::REG_OUTER:  outer_r  <= cfg_data[19:0];
        rdrs_pkg::REG_RATIO:  ratio_r  <= cfg_data[15:0];
        rdrs_pkg::REG_MODE:   mode_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // radii in 2^-13 angstrom and their squares, refreshed every cycle
  logic [rdrs_pkg::SPAN_W-1:0] rad_a, rad_b, span, half_span;
  logic [rdrs_pkg::SQ_W-1:0]   a2_r, b2_r;

  assign rad_a     = {inner_r, 9'd0};
  assign rad_b     = {outer_r, 9'd0};
  assign span      = rad_b - rad_a;
  assign half_span = {1'b0, span[rdrs_pkg::SPAN_W-1:1]};

  always_ff @(posedge clk) begin
    a2_r <= {(2*rdrs_pkg::RAD_W)'(inner_r) * (2*rdrs_pkg::RAD_W)'(inner_r), 18'd0};
    b2_r <= {(2*rdrs_pkg::RAD_W)'(outer_r) * (2*rdrs_pkg::RAD_W)'(outer_r), 18'd0};
  end

  // chain advance: frozen only while a result waits unaccepted
  logic adv;
  logic out_vld_r;
  logic [31:0] out_r;

  assign adv        = !out_vld_r || out_tready;
  assign in_tready  = adv;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_r;

  // valid, density and zone lines beside the datapath
  logic                       vld_r  [0:PST];
  logic [rdrs_pkg::DENS_W-1:0] dens_r [0:QST];
  rdrs_pkg::zone_t            zone_r [3:QST];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= PST; k++) vld_r[k] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_tvalid;
      for (int k = 1; k <= PST; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dens_r[0] <= in_tdata[55:24];
      for (int k = 1; k <= QST; k++) dens_r[k] <= dens_r[k-1];
    end
  end

  // stage 0: voxel indexes
  logic [rdrs_pkg::IDX_W-1:0] col_r, row_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      col_r <= in_tdata[11:0];
      row_r <= in_tdata[23:12];
    end
  end

  // stage 1: doubled centre offsets scaled by pixel length
  logic signed [13:0]         dx, dy;
  logic [rdrs_pkg::DIM_W-1:0] mx, my;
  logic [rdrs_pkg::OFS_W-1:0] ax_r, ay_r;

  always_comb begin
    dx = $signed({1'b0, col_r, 1'b1}) - $signed({1'b0, width_r});
    dy = $signed({1'b0, row_r, 1'b1}) - $signed({1'b0, height_r});
    mx = dx[13] ? 13'(-dx) : dx[12:0];
    my = dy[13] ? 13'(-dy) : dy[12:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ax_r <= rdrs_pkg::OFS_W'(mx) * rdrs_pkg::OFS_W'(lenx_r);
      ay_r <= rdrs_pkg::OFS_W'(my) * rdrs_pkg::OFS_W'(leny_r);
    end
  end

  // stage 2: squares
  logic [rdrs_pkg::SQ_W-1:0] sqx_r, sqy_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      sqx_r <= rdrs_pkg::SQ_W'(ax_r) * rdrs_pkg::SQ_W'(ax_r);
      sqy_r <= rdrs_pkg::SQ_W'(ay_r) * rdrs_pkg::SQ_W'(ay_r);
    end
  end

  // stage 3: squared distance and zone, zone line shifts along
  logic [rdrs_pkg::SUM_W-1:0] ssum, s_r;
  assign ssum = {1'b0, sqx_r} + {1'b0, sqy_r};

  always_ff @(posedge clk) begin
    if (adv) begin
      s_r <= ssum;
      if (ssum <= {1'b0, a2_r}) begin
        zone_r[3] <= rdrs_pkg::ZONE_IN;
      end else if (ssum <= {1'b0, b2_r}) begin
        zone_r[3] <= rdrs_pkg::ZONE_RAMP;
      end else begin
        zone_r[3] <= rdrs_pkg::ZONE_OUT;
      end
      for (int k = 4; k <= QST; k++) zone_r[k] <= zone_r[k-1];
    end
  end

  // root chain: one bit per cell
  logic [rdrs_pkg::SREM_W-1:0] srem [0:rdrs_pkg::SQRT_N];
  logic [rdrs_pkg::ROOT_W-1:0] sroot[0:rdrs_pkg::SQRT_N];
  logic [rdrs_pkg::RADC_W-1:0] srad [0:rdrs_pkg::SQRT_N];

  assign srem[0]  = '0;
  assign sroot[0] = '0;
  assign srad[0]  = {1'b0, s_r};

  for (genvar j = 0; j < rdrs_pkg::SQRT_N; j++) begin : g_sqrt
    rdrs_sqrt_cell u_cell (
      .clk    (clk),
      .en     (adv),
      .rem_i  (srem[j]),
      .root_i (sroot[j]),
      .rad_i  (srad[j]),
      .rem_o  (srem[j+1]),
      .root_o (sroot[j+1]),
      .rad_o  (srad[j+1])
    );
  end

  // numerator stage: ramp position and weighted ratio
  logic [rdrs_pkg::ROOT_W-1:0] tpos;
  logic [rdrs_pkg::SPAN_W-1:0] tcl;
  logic [rdrs_pkg::NUM_W-1:0]  wa, wb, num;
  logic [rdrs_pkg::DNUM_W-1:0] dnum_r;

  always_comb begin
    tpos = (sroot[rdrs_pkg::SQRT_N] > {1'b0, rad_a}) ?
           (sroot[rdrs_pkg::SQRT_N] - {1'b0, rad_a}) : '0;
    tcl  = (tpos > {1'b0, span}) ? span : tpos[rdrs_pkg::SPAN_W-1:0];
    wa   = rdrs_pkg::NUM_W'(span - tcl);
    wb   = rdrs_pkg::NUM_W'(tcl);
    if (!mode_r) begin
      num = rdrs_pkg::NUM_W'(ratio_r) * wa + {wb[rdrs_pkg::NUM_W-13:0], 12'd0};
    end else begin
      num = rdrs_pkg::NUM_W'(ratio_r) * wb + {wa[rdrs_pkg::NUM_W-13:0], 12'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dnum_r <= {num, 12'd0} + rdrs_pkg::DNUM_W'(half_span);
    end
  end

  // divider chain: one quotient bit per cell
  logic [rdrs_pkg::SPAN_W-1:0] drem [0:rdrs_pkg::DIV_N];
  logic [rdrs_pkg::QUO_W-1:0]  dnumq[0:rdrs_pkg::DIV_N];
  logic [rdrs_pkg::QUO_W-1:0]  dquo [0:rdrs_pkg::DIV_N];

  assign drem[0]  = dnum_r[rdrs_pkg::DNUM_W-2:rdrs_pkg::QUO_W];
  assign dnumq[0] = dnum_r[rdrs_pkg::QUO_W-1:0];
  assign dquo[0]  = '0;

  for (genvar j = 0; j < rdrs_pkg::DIV_N; j++) begin : g_div
    rdrs_div_cell u_cell (
      .clk   (clk),
      .en    (adv),
      .span  (span),
      .rem_i (drem[j]),
      .num_i (dnumq[j]),
      .quo_i (dquo[j]),
      .rem_o (drem[j+1]),
      .num_o (dnumq[j+1]),
      .quo_o (dquo[j+1])
    );
  end

  // product stage: factor in Q.24 times density
  logic [rdrs_pkg::FAC_W-1:0]        fac, fac_ratio;
  logic signed [rdrs_pkg::PROD_W-1:0] prod_r;

  assign fac_ratio = {1'b0, ratio_r, 12'd0};

  always_comb begin
    case (zone_r[QST])
      rdrs_pkg::ZONE_IN:   fac = mode_r ? 29'd16777216 : fac_ratio;
      rdrs_pkg::ZONE_RAMP: fac = {1'b0, dquo[rdrs_pkg::DIV_N]};
      default:             fac = mode_r ? fac_ratio : 29'd16777216;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= rdrs_pkg::PROD_W'($signed(dens_r[QST])) *
                rdrs_pkg::PROD_W'($signed({1'b0, fac}));
    end
  end

  // output stage: round by 24 bits, saturate
  logic [rdrs_pkg::PROD_W-1:0] mag;
  logic [rdrs_pkg::PROD_W-1:0] rnd;
  logic [37:0]                 qv;
  logic [31:0]                 res;

  always_comb begin
    mag = prod_r[rdrs_pkg::PROD_W-1] ? rdrs_pkg::PROD_W'(-prod_r) : prod_r;
    rnd = mag + rdrs_pkg::PROD_W'(62'd8388608);
    qv  = rnd[rdrs_pkg::PROD_W-1:24];
    if (prod_r[rdrs_pkg::PROD_W-1]) begin
      res = (qv > 38'd2147483648) ? 32'h8000_0000 : 32'(-qv[31:0]);
    end else begin
      res = (qv > 38'd2147483647) ? 32'h7FFF_FFFF : qv[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= vld_r[PST];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= res;
    end
  end

endmodule

// ----- sv/rdrs_sqrt_cell.sv -----
module rdrs_sqrt_cell (
  input  logic                              clk,
  input  logic                              en,
  input  logic [rdrs_pkg::SREM_W-1:0]       rem_i,
  input  logic [rdrs_pkg::ROOT_W-1:0]       root_i,
  input  logic [rdrs_pkg::RADC_W-1:0]       rad_i,
  output logic [rdrs_pkg::SREM_W-1:0]       rem_o,
  output logic [rdrs_pkg::ROOT_W-1:0]       root_o,
  output logic [rdrs_pkg::RADC_W-1:0]       rad_o
);

  logic [rdrs_pkg::SREM_W-1:0] cur;
  logic [rdrs_pkg::SREM_W-1:0] trial;
  logic                        ge;

  // bring down the next two radicand bits and try one root bit
  always_comb begin
    cur   = {rem_i[rdrs_pkg::SREM_W-3:0], rad_i[rdrs_pkg::RADC_W-1 -: 2]};
    trial = {root_i, 2'b01};
    ge    = (cur >= trial);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o  <= ge ? (cur - trial) : cur;
      root_o <= {root_i[rdrs_pkg::ROOT_W-2:0], ge};
      rad_o  <= {rad_i[rdrs_pkg::RADC_W-3:0], 2'b00};
    end
  end

endmodule

// ----- sv/rdrs_div_cell.sv -----
module rdrs_div_cell (
  input  logic                              clk,
  input  logic                              en,
  input  logic [rdrs_pkg::SPAN_W-1:0]       span,
  input  logic [rdrs_pkg::SPAN_W-1:0]       rem_i,
  input  logic [rdrs_pkg::QUO_W-1:0]        num_i,
  input  logic [rdrs_pkg::QUO_W-1:0]        quo_i,
  output logic [rdrs_pkg::SPAN_W-1:0]       rem_o,
  output logic [rdrs_pkg::QUO_W-1:0]        num_o,
  output logic [rdrs_pkg::QUO_W-1:0]        quo_o
);

  logic [rdrs_pkg::SPAN_W:0] cur;
  logic [rdrs_pkg::SPAN_W:0] diff;
  logic                      ge;

  // shift in one dividend bit and subtract the span when it fits
  always_comb begin
    cur  = {rem_i, num_i[rdrs_pkg::QUO_W-1]};
    diff = cur - {1'b0, span};
    ge   = (cur >= {1'b0, span});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o <= ge ? diff[rdrs_pkg::SPAN_W-1:0] : cur[rdrs_pkg::SPAN_W-1:0];
      num_o <= {num_i[rdrs_pkg::QUO_W-2:0], 1'b0};
      quo_o <= {quo_i[rdrs_pkg::QUO_W-2:0], ge};
    end
  end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

  // voxel transaction as offered to the block
  typedef struct packed {
    logic [31:0] density;
    logic [11:0] row;
    logic [11:0] col;
  } voxel_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;   // col_index[11:0], row_index[23:12], density_in[55:24]
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // density_out[31:0]
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  radial_density_ramp_scaler dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor copy of the registers
  logic [12:0] m_width, m_height;
  logic [15:0] m_lenx, m_leny, m_ratio;
  logic [19:0] m_inner, m_outer;
  logic        m_mode;

  voxel_t      pending_voxels[$];
  logic [31:0] expected_density[$];
  int          send_idle_pct, recv_idle_pct;
  int          hold_cycles;
  int          mismatches;

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // timeout
  initial begin
    #40_000_000;
    $display("testbench: errors");
    $finish;
  end

  function automatic logic [12:0] clamp_dim(logic [31:0] v);
    logic [12:0] w;
    w = v[12:0];
    if (w < 13'd1) return 13'd1;
    if (w > 13'd4096) return 13'd4096;
    return w;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] round_saturate(logic signed [63:0] p, int k);
    logic [63:0] mag, q;
    mag = p[63] ? -p : p;
    q = (mag + (64'd1 << (k - 1))) >> k;
    if (p[63]) return (q > 64'h8000_0000) ? 32'h8000_0000 : 32'(-q);
    return (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
  endfunction

  function automatic logic [63:0] axis_offset(logic [11:0] i, logic [12:0] n,
                                              logic [15:0] len);
    logic signed [63:0] d2;
    d2 = 64'(2 * i + 1) - 64'(n);
    if (d2 < 0) d2 = -d2;
    return d2 * len;
  endfunction

  function automatic logic [31:0] scaled_density(voxel_t v);
    logic signed [63:0] dens;
    logic [63:0] ax, ay, s, a, b, r, span, t, num, f;
    dens = $signed(v.density);
    ax = axis_offset(v.col, m_width, m_lenx);
    ay = axis_offset(v.row, m_height, m_leny);
    s = ax * ax + ay * ay;
    a = 64'(m_inner) * 512;
    b = 64'(m_outer) * 512;
    if (s <= a * a)
      return m_mode ? v.density : round_saturate(dens * $signed({48'd0, m_ratio}), 12);
    if (s <= b * b) begin
      r = int_sqrt(s);
      span = b - a;
      t = (r > a) ? r - a : 0;
      if (t > span) t = span;
      if (!m_mode) num = m_ratio * (span - t) + 4096 * t;
      else num = 4096 * (span - t) + m_ratio * t;
      f = (num * 4096 + span / 2) / span;
      return round_saturate(dens * $signed(f), 24);
    end
    return m_mode ? round_saturate(dens * $signed({48'd0, m_ratio}), 12) : v.density;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (pending_voxels.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_tdata <= pending_voxels[0];
        expected_density.push_back(scaled_density(pending_voxels[0]));
        void'(pending_voxels.pop_front());
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver readiness, with an optional long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_density.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_tdata);
      end else begin
        if (out_tdata !== expected_density[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("density mismatch: expected %h actual %h",
                     expected_density[0], out_tdata);
        end
        void'(expected_density.pop_front());
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      rdrs_pkg::REG_WIDTH:  m_width = clamp_dim(val);
      rdrs_pkg::REG_HEIGHT: m_height = clamp_dim(val);
      rdrs_pkg::REG_LENX:   m_lenx = val[15:0];
      rdrs_pkg::REG_LENY:   m_leny = val[15:0];
      rdrs_pkg::REG_INNER:  m_inner = val[19:0];
      rdrs_pkg::REG_OUTER:  m_outer = val[19:0];
      rdrs_pkg::REG_RATIO:  m_ratio = val[15:0];
      rdrs_pkg::REG_MODE:   m_mode = val[0];
      default: ;
    endcase
  endtask

  task automatic drain_chain();
    while (pending_voxels.size() > 0 || in_tvalid || expected_density.size() > 0)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic load_setting(logic [12:0] w, logic [12:0] h, logic [15:0] lx,
                              logic [15:0] ly, logic [19:0] ri, logic [19:0] ro,
                              logic [15:0] rat, logic md);
    drain_chain();
    write_reg(rdrs_pkg::REG_WIDTH, 32'(w));
    write_reg(rdrs_pkg::REG_HEIGHT, 32'(h));
    write_reg(rdrs_pkg::REG_LENX, 32'(lx));
    write_reg(rdrs_pkg::REG_LENY, 32'(ly));
    write_reg(rdrs_pkg::REG_INNER, 32'(ri));
    write_reg(rdrs_pkg::REG_OUTER, 32'(ro));
    write_reg(rdrs_pkg::REG_RATIO, 32'(rat));
    write_reg(rdrs_pkg::REG_MODE, 32'(md));
  endtask

  // density biased toward extremes and small values
  function automatic logic [31:0] rand_density();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF - $urandom_range(3);
      1: return 32'h8000_0000 + $urandom_range(3);
      2: return 32'($signed($urandom_range(2000)) - 1000);
      default: return $urandom;
    endcase
  endfunction

  // index mostly inside a small image, sometimes anywhere
  function automatic voxel_t rand_voxel();
    voxel_t v;
    if ($urandom_range(9) == 0) begin
      v.col = 12'($urandom);
      v.row = 12'($urandom);
    end else begin
      v.col = 12'($urandom_range(m_width > 1 ? m_width - 1 : 0));
      v.row = 12'($urandom_range(m_height > 1 ? m_height - 1 : 0));
    end
    v.density = rand_density();
    return v;
  endfunction

  task automatic add_voxel(logic [11:0] c, logic [11:0] r, logic [31:0] d);
    voxel_t v;
    v.col = c;
    v.row = r;
    v.density = d;
    pending_voxels.push_back(v);
  endtask

  task automatic random_phase(int count);
    repeat (count) pending_voxels.push_back(rand_voxel());
  endtask

  // stimulus
  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    send_idle_pct = 30;
    recv_idle_pct = 80;
    hold_cycles = 0;
    mismatches = 0;
    m_width = 1; m_height = 1; m_lenx = 4096; m_leny = 4096;
    m_inner = 0; m_outer = 16; m_ratio = 4096; m_mode = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset defaults, extreme densities and indexes
    add_voxel(0, 0, 32'h7FFF_FFFF);
    add_voxel(12'hFFF, 12'hFFF, 32'h8000_0000);
    add_voxel(1, 0, 32'd12345);
    // ramp setting with overflow ratio in mode 0, then zero ratio in mode 1
    load_setting(64, 48, 16'h1800, 16'h0800, 20'd40, 20'd400, 16'hFFFF, 1'b0);
    add_voxel(32, 24, 32'h7FFF_FFFF);
    add_voxel(31, 23, 32'h8000_0000);
    add_voxel(0, 0, 32'hFFFF_FFFF);
    add_voxel(63, 47, 32'd1000);
    add_voxel(50, 10, 32'h4000_0000);
    add_voxel(12'hFFF, 0, 32'hC000_0000);
    load_setting(64, 48, 16'h1800, 16'h0800, 20'd40, 20'd400, 16'd0, 1'b1);
    add_voxel(32, 24, 32'h7FFF_FFFF);
    add_voxel(50, 10, 32'h8000_0000);
    add_voxel(0, 0, 32'd777);
    // empty ramp, zero pixel length, dimensions out of range
    load_setting(0, 13'h1FFF, 16'd0, 16'hFFFF, 20'hFFFFF, 20'd5, 16'h2000, 1'b0);
    add_voxel(0, 0, 32'd99);
    add_voxel(4095, 4095, 32'h8000_0001);
    add_voxel(2048, 100, 32'h7FFF_FFFF);
    load_setting(5000, 0, 16'hFFFF, 16'd0, 20'd0, 20'hFFFFF, 16'h0001, 1'b1);
    add_voxel(0, 0, 32'h7FFF_FFFF);
    add_voxel(4095, 4095, 32'h8000_0000);
    add_voxel(100, 0, 32'hFFFF_FFFF);

    // random settings across three idling regimes
    for (int ph = 0; ph < 9; ph++) begin
      send_idle_pct = (ph < 3) ? 30 : (ph < 6) ? 80 : 0;
      recv_idle_pct = (ph < 3) ? 80 : (ph < 6) ? 30 : 0;
      load_setting(13'($urandom_range(1, 200)), 13'($urandom_range(1, 200)),
                   16'($urandom_range(65535)), 16'($urandom_range(65535)),
                   20'($urandom_range(3000)), 20'($urandom_range(1, 20000)),
                   16'($urandom_range(65535)), ph[0]);
      if (ph == 7) hold_cycles = 300;
      random_phase(160);
    end
    drain_chain();
    if (mismatches == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

endmodule
